[rtl/assert_macros.svh]
// Assertion helpers used by hpm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define HPM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property, checked in and out of reset.
`define HPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/hpm_pkg.sv]
package hpm_pkg;

    localparam int HPM_PIXEL_BITS     = 16;
    localparam int HPM_COEF_FRAC_BITS = 40;

    localparam int HPM_COEF_W    = 64;
    localparam int HPM_IN_W      = 30;
    localparam int HPM_REG_NUM   = 8;
    localparam int HPM_REG_IDX_W = 3;
    localparam int HPM_ADDR_W    = HPM_REG_IDX_W + 3;
    localparam int HPM_DATA_W    = 64;

    // |coef * in| <= 2^93, two products plus a 64-bit constant stay below 2^95
    localparam int HPM_LIN_W = 96;
    // 2*|n| + |w| stays below 2^97
    localparam int HPM_NUM_W = HPM_LIN_W + 1;

    typedef enum logic [HPM_REG_IDX_W-1:0] {
        REG_M00,
        REG_M01,
        REG_M02,
        REG_M10,
        REG_M11,
        REG_M12,
        REG_M20,
        REG_M21
    } t_hpm_reg;

    // sign and special-case bits that ride along with the division
    typedef struct packed {
        logic wzero;
        logic dneg;
        logic xneg;
        logic yneg;
    } t_hpm_tag;

endpackage

[rtl/hpm_in_if.sv]
interface hpm_in_if;
    import hpm_pkg::*;

    logic                valid;
    logic                ready;
    logic [HPM_IN_W-1:0] lat_count;
    logic [HPM_IN_W-1:0] lon_count;

    modport source (output valid, output lat_count, output lon_count, input ready);
    modport sink   (input valid, input lat_count, input lon_count, output ready);
endinterface

[rtl/hpm_out_if.sv]
interface hpm_out_if #(
    parameter int PIXEL_BITS = hpm_pkg::HPM_PIXEL_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_x;
    logic signed [PIXEL_BITS-1:0] pixel_y;
    logic                         range_flag;

    modport source (output valid, output pixel_x, output pixel_y, output range_flag,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input range_flag,
                    output ready);
endinterface

[rtl/hpm_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, two numerators
// sharing one denominator. Quotient bit PIXEL_BITS is set when q >= 2^PIXEL_BITS.
module hpm_div_pipe #(
    parameter int PIXEL_BITS = hpm_pkg::HPM_PIXEL_BITS,
    parameter int NUM_W      = hpm_pkg::HPM_NUM_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [NUM_W-1:0]      i_num_x,
    input  logic [NUM_W-1:0]      i_num_y,
    input  logic [NUM_W-1:0]      i_den,
    input  hpm_pkg::t_hpm_tag     i_tag,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIXEL_BITS:0]   o_quot_x,
    output logic [PIXEL_BITS:0]   o_quot_y,
    output hpm_pkg::t_hpm_tag     o_tag
);
    import hpm_pkg::*;

    localparam int STEPS = PIXEL_BITS + 1;
    localparam int CMP_W = NUM_W + PIXEL_BITS;

    logic [STEPS-1:0]  r_v;
    logic [NUM_W-1:0]  r_rx  [STEPS];
    logic [NUM_W-1:0]  r_ry  [STEPS];
    logic [NUM_W-1:0]  r_d   [STEPS];
    logic [PIXEL_BITS:0] r_qx [STEPS];
    logic [PIXEL_BITS:0] r_qy [STEPS];
    t_hpm_tag          r_tag [STEPS];

    logic [STEPS-1:0]  s_v;
    logic [NUM_W-1:0]  s_rx  [STEPS];
    logic [NUM_W-1:0]  s_ry  [STEPS];
    logic [NUM_W-1:0]  s_d   [STEPS];
    logic [PIXEL_BITS:0] s_qx [STEPS];
    logic [PIXEL_BITS:0] s_qy [STEPS];
    t_hpm_tag          s_tag [STEPS];

    logic [NUM_W-1:0]  n_rx  [STEPS];
    logic [NUM_W-1:0]  n_ry  [STEPS];
    logic [PIXEL_BITS:0] n_qx [STEPS];
    logic [PIXEL_BITS:0] n_qy [STEPS];

    logic [STEPS-1:0]  rdy;

    // stage sources
    always_comb begin
        s_v[0]   = i_valid;
        s_rx[0]  = i_num_x;
        s_ry[0]  = i_num_y;
        s_d[0]   = i_den;
        s_qx[0]  = '0;
        s_qy[0]  = '0;
        s_tag[0] = i_tag;
        for (int j = 1; j < STEPS; j++) begin
            s_v[j]   = r_v[j-1];
            s_rx[j]  = r_rx[j-1];
            s_ry[j]  = r_ry[j-1];
            s_d[j]   = r_d[j-1];
            s_qx[j]  = r_qx[j-1];
            s_qy[j]  = r_qy[j-1];
            s_tag[j] = r_tag[j-1];
        end
    end

    // one trial subtract per lane per stage, stage j decides bit PIXEL_BITS-j
    always_comb begin
        logic [CMP_W-1:0] dsh;
        logic [CMP_W-1:0] ex;
        logic [CMP_W-1:0] ey;
        logic [CMP_W-1:0] dx;
        logic [CMP_W-1:0] dy;
        for (int j = 0; j < STEPS; j++) begin
            dsh = {{PIXEL_BITS{1'b0}}, s_d[j]} << (PIXEL_BITS - j);
            ex  = {{PIXEL_BITS{1'b0}}, s_rx[j]};
            ey  = {{PIXEL_BITS{1'b0}}, s_ry[j]};
            dx  = ex - dsh;
            dy  = ey - dsh;
            n_qx[j] = s_qx[j];
            n_qy[j] = s_qy[j];
            n_qx[j][PIXEL_BITS-j] = (ex >= dsh);
            n_qy[j][PIXEL_BITS-j] = (ey >= dsh);
            n_rx[j] = (ex >= dsh) ? dx[NUM_W-1:0] : s_rx[j];
            n_ry[j] = (ey >= dsh) ? dy[NUM_W-1:0] : s_ry[j];
        end
    end

    // a stage loads when empty or when its contents move on
    always_comb begin
        rdy[STEPS-1] = !r_v[STEPS-1] || i_ready;
        for (int j = STEPS - 2; j >= 0; j--) begin
            rdy[j] = !r_v[j] || rdy[j+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int j = 0; j < STEPS; j++) begin
                if (rdy[j]) begin
                    r_v[j] <= s_v[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < STEPS; j++) begin
            if (rdy[j] && s_v[j]) begin
                r_rx[j]  <= n_rx[j];
                r_ry[j]  <= n_ry[j];
                r_d[j]   <= s_d[j];
                r_qx[j]  <= n_qx[j];
                r_qy[j]  <= n_qy[j];
                r_tag[j] <= s_tag[j];
            end
        end
    end

    assign o_ready  = rdy[0];
    assign o_valid  = r_v[STEPS-1];
    assign o_quot_x = r_qx[STEPS-1];
    assign o_quot_y = r_qy[STEPS-1];
    assign o_tag    = r_tag[STEPS-1];

endmodule

[rtl/homography_point_map.sv]
// Projective point mapper: each item (lat_count, lon_count) becomes one pixel
// (pixel_x, pixel_y, range_flag) through w = m20*x + m21*y + 1,
// pixel = round((m*0*x + m*1*y + m*2) / w), rounding half away from zero.
// Coefficients are signed Q24.40 (COEF_FRAC_BITS fraction bits), 64-bit
// registers at byte address 8*i in the order m00 m01 m02 m10 m11 m12 m20 m21;
// reset gives the identity map. Results clamp to the signed PIXEL_BITS range
// and set range_flag; a zero w gives 0, 0 with range_flag set. Write the
// coefficients only while no items are in flight.
// Throughput is one item per clock unless the output stalls. The path from
// acceptance to the result runs through five arithmetic stages
// (partial products, product sums, linear sums, magnitudes, rounding operands),
// PIXEL_BITS + 1 stages of the restoring divider, one bit each, and the
// output register. Each stage holds its item under backpressure, so bubbles
// keep filling while a result waits.
module homography_point_map #(
    parameter int PIXEL_BITS     = hpm_pkg::HPM_PIXEL_BITS,
    parameter int COEF_FRAC_BITS = hpm_pkg::HPM_COEF_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    hpm_in_if.sink                           i_pt,
    hpm_out_if.source                        o_px,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hpm_pkg::HPM_ADDR_W-1:0]   paddr,
    input  logic [hpm_pkg::HPM_DATA_W-1:0]   pwdata,
    output logic [hpm_pkg::HPM_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import hpm_pkg::*;

    localparam int HALF_W = HPM_COEF_W / 2;
    localparam int PH_W   = HALF_W + HPM_IN_W + 1;   // signed high half times input
    localparam int PL_W   = HALF_W + HPM_IN_W;       // unsigned low half times input
    localparam int NPROD  = 6;
    localparam int FSTG   = 5;

    localparam logic [HPM_COEF_W-1:0] COEF_ONE = HPM_COEF_W'(1) << COEF_FRAC_BITS;
    localparam logic [PIXEL_BITS:0]   HALF_Q   = (PIXEL_BITS + 1)'(1) << (PIXEL_BITS - 1);
    localparam logic [PIXEL_BITS-1:0] NEG_MIN  = PIXEL_BITS'(1) << (PIXEL_BITS - 1);
    localparam logic [PIXEL_BITS-1:0] POS_MAX  = ~NEG_MIN;

    // ------------------------------------------------------------------
    // Coefficient registers, APB write in the access phase
    // ------------------------------------------------------------------
    logic [HPM_COEF_W-1:0] r_coef [HPM_REG_NUM];
    t_hpm_reg              reg_idx;

    assign reg_idx = t_hpm_reg'(paddr[HPM_ADDR_W-1:3]);
    assign pready  = 1'b1;
    assign prdata  = r_coef[reg_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // identity map: m00 = m11 = 1.0, the rest 0
            for (int k = 0; k < HPM_REG_NUM; k++) begin
                r_coef[k] <= (k == int'(REG_M00) || k == int'(REG_M11)) ? COEF_ONE : '0;
            end
        end else if (psel && penable && pwrite && pready) begin
            r_coef[reg_idx] <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // Front pipeline control
    // ------------------------------------------------------------------
    logic [FSTG-1:0] r_fv;
    logic [FSTG-1:0] fr_rdy;
    logic            div_rdy;

    always_comb begin
        fr_rdy[FSTG-1] = !r_fv[FSTG-1] || div_rdy;
        for (int k = FSTG - 2; k >= 0; k--) begin
            fr_rdy[k] = !r_fv[k] || fr_rdy[k+1];
        end
    end

    assign i_pt.ready = fr_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else begin
            if (fr_rdy[0]) begin
                r_fv[0] <= i_pt.valid;
            end
            for (int k = 1; k < FSTG; k++) begin
                if (fr_rdy[k]) begin
                    r_fv[k] <= r_fv[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: 32-bit partial products. Product order:
    // m00*x, m01*y, m10*x, m11*y, m20*x, m21*y
    // ------------------------------------------------------------------
    logic [HPM_COEF_W-1:0] pp_coef [NPROD];
    logic [HPM_IN_W-1:0]   pp_in   [NPROD];
    logic [PH_W-1:0]       n_pp_hi [NPROD];
    logic [PL_W-1:0]       n_pp_lo [NPROD];
    logic [PH_W-1:0]       r_pp_hi [NPROD];
    logic [PL_W-1:0]       r_pp_lo [NPROD];

    always_comb begin
        pp_coef[0] = r_coef[REG_M00];
        pp_coef[1] = r_coef[REG_M01];
        pp_coef[2] = r_coef[REG_M10];
        pp_coef[3] = r_coef[REG_M11];
        pp_coef[4] = r_coef[REG_M20];
        pp_coef[5] = r_coef[REG_M21];
        for (int k = 0; k < NPROD; k++) begin
            pp_in[k]   = (k % 2 == 0) ? i_pt.lat_count : i_pt.lon_count;
            // signed high word times zero-extended input
            n_pp_hi[k] = PH_W'($signed(pp_coef[k][HPM_COEF_W-1:HALF_W])
                               * $signed({1'b0, pp_in[k]}));
            n_pp_lo[k] = PL_W'(pp_coef[k][HALF_W-1:0] * pp_in[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fr_rdy[0] && i_pt.valid) begin
            for (int k = 0; k < NPROD; k++) begin
                r_pp_hi[k] <= n_pp_hi[k];
                r_pp_lo[k] <= n_pp_lo[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: full products, hi << 32 + lo
    // ------------------------------------------------------------------
    logic [HPM_LIN_W-1:0] n_prod [NPROD];
    logic [HPM_LIN_W-1:0] r_prod [NPROD];

    always_comb begin
        for (int k = 0; k < NPROD; k++) begin
            n_prod[k] = ({{(HPM_LIN_W-PH_W){r_pp_hi[k][PH_W-1]}}, r_pp_hi[k]} << HALF_W)
                      + {{(HPM_LIN_W-PL_W){1'b0}}, r_pp_lo[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (fr_rdy[1] && r_fv[0]) begin
            for (int k = 0; k < NPROD; k++) begin
                r_prod[k] <= n_prod[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: linear forms nx, ny, w
    // ------------------------------------------------------------------
    logic [HPM_LIN_W-1:0] n_lin [3];
    logic [HPM_LIN_W-1:0] r_lin [3];

    always_comb begin
        n_lin[0] = r_prod[0] + r_prod[1]
                 + {{(HPM_LIN_W-HPM_COEF_W){r_coef[REG_M02][HPM_COEF_W-1]}}, r_coef[REG_M02]};
        n_lin[1] = r_prod[2] + r_prod[3]
                 + {{(HPM_LIN_W-HPM_COEF_W){r_coef[REG_M12][HPM_COEF_W-1]}}, r_coef[REG_M12]};
        n_lin[2] = r_prod[4] + r_prod[5]
                 + {{(HPM_LIN_W-HPM_COEF_W){1'b0}}, COEF_ONE};
    end

    always_ff @(posedge i_clk) begin
        if (fr_rdy[2] && r_fv[1]) begin
            for (int k = 0; k < 3; k++) begin
                r_lin[k] <= n_lin[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: magnitudes and signs
    // ------------------------------------------------------------------
    logic [HPM_LIN_W-1:0] n_abs [3];
    logic [HPM_LIN_W-1:0] r_abs [3];
    t_hpm_tag             n_tag3;
    t_hpm_tag             r_tag3;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_abs[k] = r_lin[k][HPM_LIN_W-1] ? (HPM_LIN_W'(0) - r_lin[k]) : r_lin[k];
        end
        n_tag3.xneg  = r_lin[0][HPM_LIN_W-1];
        n_tag3.yneg  = r_lin[1][HPM_LIN_W-1];
        n_tag3.dneg  = r_lin[2][HPM_LIN_W-1];
        n_tag3.wzero = (r_lin[2] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (fr_rdy[3] && r_fv[2]) begin
            for (int k = 0; k < 3; k++) begin
                r_abs[k] <= n_abs[k];
            end
            r_tag3 <= n_tag3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: rounding operands, q = (2|n| + |w|) / (2|w|)
    // ------------------------------------------------------------------
    logic [HPM_NUM_W-1:0] r_num_x;
    logic [HPM_NUM_W-1:0] r_num_y;
    logic [HPM_NUM_W-1:0] r_den;
    t_hpm_tag             r_tag4;

    always_ff @(posedge i_clk) begin
        if (fr_rdy[4] && r_fv[3]) begin
            r_num_x <= {r_abs[0], 1'b0} + {1'b0, r_abs[2]};
            r_num_y <= {r_abs[1], 1'b0} + {1'b0, r_abs[2]};
            r_den   <= {r_abs[2], 1'b0};
            r_tag4  <= r_tag3;
        end
    end

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    logic                div_vld;
    logic                out_rdy;
    logic [PIXEL_BITS:0] div_qx;
    logic [PIXEL_BITS:0] div_qy;
    t_hpm_tag            div_tag;

    hpm_div_pipe #(
        .PIXEL_BITS (PIXEL_BITS),
        .NUM_W      (HPM_NUM_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_fv[FSTG-1]),
        .o_ready  (div_rdy),
        .i_num_x  (r_num_x),
        .i_num_y  (r_num_y),
        .i_den    (r_den),
        .i_tag    (r_tag4),
        .o_valid  (div_vld),
        .i_ready  (out_rdy),
        .o_quot_x (div_qx),
        .o_quot_y (div_qy),
        .o_tag    (div_tag)
    );

    // ------------------------------------------------------------------
    // Output stage: sign, clamp, flag
    // ------------------------------------------------------------------
    // returns {saturated, value}
    function automatic logic [PIXEL_BITS:0] f_round(input logic [PIXEL_BITS:0] q,
                                                    input logic neg);
        logic [PIXEL_BITS:0] res;
        if (neg) begin
            if (q > HALF_Q) begin
                res = {1'b1, NEG_MIN};
            end else begin
                res = {1'b0, PIXEL_BITS'(0) - q[PIXEL_BITS-1:0]};
            end
        end else begin
            if (q >= HALF_Q) begin
                res = {1'b1, POS_MAX};
            end else begin
                res = {1'b0, q[PIXEL_BITS-1:0]};
            end
        end
        return res;
    endfunction

    logic [PIXEL_BITS:0]   rnd_x;
    logic [PIXEL_BITS:0]   rnd_y;
    logic                  r_ov;
    logic [PIXEL_BITS-1:0] r_px;
    logic [PIXEL_BITS-1:0] r_py;
    logic                  r_flag;

    assign rnd_x   = f_round(div_qx, div_tag.xneg ^ div_tag.dneg);
    assign rnd_y   = f_round(div_qy, div_tag.yneg ^ div_tag.dneg);
    assign out_rdy = !r_ov || o_px.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_rdy) begin
            r_ov <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && div_vld) begin
            // zero denominator: both pixels 0, flag set
            r_px   <= div_tag.wzero ? '0 : rnd_x[PIXEL_BITS-1:0];
            r_py   <= div_tag.wzero ? '0 : rnd_y[PIXEL_BITS-1:0];
            r_flag <= div_tag.wzero | rnd_x[PIXEL_BITS] | rnd_y[PIXEL_BITS];
        end
    end

    assign o_px.valid      = r_ov;
    assign o_px.pixel_x    = r_px;
    assign o_px.pixel_y    = r_py;
    assign o_px.range_flag = r_flag;

endmodule

[rtl/hpm_checker.sv]
`include "assert_macros.svh"

module hpm_checker #(
    parameter int PIXEL_BITS = hpm_pkg::HPM_PIXEL_BITS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [PIXEL_BITS-1:0] i_pixel_x,
    input logic [PIXEL_BITS-1:0] i_pixel_y,
    input logic                  i_range_flag,
    input logic                  i_pready
);

    // an empty output register means every stage can take an item
    `HPM_ASSERT(a_ready_when_drained, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "input stalled with empty output")

    // input backpressure only comes from a result left waiting
    `HPM_ASSERT(a_stall_cause, i_clk, i_rst_n, !i_in_ready |-> (i_out_valid && !i_out_ready), "input stalled without output stall")

    `HPM_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "result dropped before taken")

    `HPM_ASSERT(a_out_stable, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> ($stable(i_pixel_x) && $stable(i_pixel_y) && $stable(i_range_flag)), "result changed while stalled")

    `HPM_ASSERT_ALWAYS(a_pready, i_clk, i_pready, "pready dropped")

endmodule

bind homography_point_map hpm_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_hpm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pt.valid),
    .i_in_ready   (i_pt.ready),
    .i_out_valid  (o_px.valid),
    .i_out_ready  (o_px.ready),
    .i_pixel_x    (o_px.pixel_x),
    .i_pixel_y    (o_px.pixel_y),
    .i_range_flag (o_px.range_flag),
    .i_pready     (pready)
);
